### rtl/core/assert_macros.svh
// Assertion macros shared by the core RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_AR(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error("assertion failed in %m");

`define ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed in %m");

`else

`define ASSERT_AR(lbl, clk, rstn, prop)

`define ASSERT_NR(lbl, clk, prop)

`endif

`endif

### rtl/core/wnsc_pkg.sv
package wnsc_pkg;

  localparam int MAX_SITES_DEF  = 64;
  localparam int COORD_BITS_DEF = 16;

  localparam int REQ_W   = 2;
  localparam int IDX_W   = 6;
  localparam int COORD_W = 16;
  localparam int RAD_W   = 16;
  localparam int R2_W    = 2 * RAD_W;
  localparam int CNT_W   = 16;
  localparam int CFG_W   = 7;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE    = 2'd0,
    REQ_CLASSIFY = 2'd1,
    REQ_READ     = 2'd2,
    REQ_CLEAR    = 2'd3
  } wnsc_req_e;

  typedef struct packed {
    wnsc_req_e                  req_type;
    logic [IDX_W-1:0]           entry_index;
    logic signed [COORD_W-1:0]  pos_x;
    logic signed [COORD_W-1:0]  pos_y;
    logic [RAD_W-1:0]           site_radius;
  } wnsc_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] nearest_index;
    logic [CNT_W-1:0] hit_count;
    logic             table_empty;
  } wnsc_out_t;

endpackage

### rtl/core/weighted_nearest_site_classifier.sv
// Channel   Direction  Handshake                    Payload
// in        input      in_valid_i / in_stall_o      in_item_i  (wnsc_in_t)
// out       output     out_valid_o / out_stall_i    out_item_o (wnsc_out_t)
// cfg       input      cfg_we_i                     cfg_wdata_i (entries in use)
//
// A write or a counter read passes through the issue and take states to the result register.
// A classify steps through the sites in use one at a time, as the one shared multiplier forms
// up to six products per site; the first site of nonzero radius forms fewer, one of zero radius none.
// A counter clear, and the pass after reset, sweep all MAX_SITES entries of the counter
// memory with the input stalled. The next item is accepted while a finished result
// waits on out_stall_i.
`include "assert_macros.svh"

module weighted_nearest_site_classifier
  import wnsc_pkg::*;
#(
  parameter int MAX_SITES  = MAX_SITES_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  wnsc_in_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output wnsc_out_t        out_item_o,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  localparam int CW     = COORD_BITS;
  localparam int CH     = CW + 1;
  localparam int A_W    = (CH > RAD_W) ? CH : RAD_W;
  localparam int P_W    = A_W + R2_W;
  localparam int SQ_W   = 2 * CW;
  localparam int DW     = 2 * CW + 1;
  localparam int WIDE_W = 2 * CH + R2_W;
  localparam int IW     = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
  localparam int CFG_MAX = (1 << CFG_W) - 1;
  localparam int LIM    = (MAX_SITES < CFG_MAX) ? MAX_SITES : CFG_MAX;
  localparam int NW     = $clog2(LIM + 1);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_CLEAR  = 5'd1;
  localparam logic [4:0] ST_ISSUE  = 5'd2;
  localparam logic [4:0] ST_TAKE   = 5'd3;
  localparam logic [4:0] ST_C_RD   = 5'd4;
  localparam logic [4:0] ST_C_DIFF = 5'd5;
  localparam logic [4:0] ST_C_SQX  = 5'd6;
  localparam logic [4:0] ST_C_SQY  = 5'd7;
  localparam logic [4:0] ST_C_SUM  = 5'd8;
  localparam logic [4:0] ST_C_L0   = 5'd9;
  localparam logic [4:0] ST_C_L1   = 5'd10;
  localparam logic [4:0] ST_C_R0   = 5'd11;
  localparam logic [4:0] ST_C_R1   = 5'd12;
  localparam logic [4:0] ST_C_CMP  = 5'd13;
  localparam logic [4:0] ST_C_CNT  = 5'd14;
  localparam logic [4:0] ST_C_UPD  = 5'd15;
  localparam logic [4:0] ST_DONE   = 5'd16;

  logic [4:0]          state_q, state_d;
  logic                boot_q, boot_d;
  logic [IW-1:0]       clr_q, clr_d;
  logic [NW-1:0]       scan_q, scan_d;
  logic                have_q, have_d;
  logic [IW-1:0]       best_q, best_d;
  logic                out_valid_q, out_valid_d;
  logic [CFG_W-1:0]    cfg_q;

  wnsc_req_e           req_q;
  logic [IDX_W-1:0]    idx_q;
  logic                in_range_q;
  logic signed [CW-1:0] px_q, py_q;
  logic [RAD_W-1:0]    rad_q;
  logic [NW-1:0]       n_q;
  logic [CW-1:0]       ax_q, ay_q;
  logic [R2_W-1:0]     r2_q;
  logic [SQ_W-1:0]     sqx_q;
  logic [DW-1:0]       d_q, bd_q;
  logic [R2_W-1:0]     br2_q;
  logic [WIDE_W-1:0]   l_q, racc_q;
  logic [IDX_W-1:0]    res_idx_q;
  logic [CNT_W-1:0]    res_cnt_q;
  logic                res_empty_q;
  wnsc_out_t           out_item_q;

  logic                 in_acc;
  logic                 out_free;
  logic signed [CW-1:0] px_in, py_in;
  logic [NW-1:0]        lim_in;
  logic                 empty_in;
  logic                 last_site;
  logic [NW-1:0]        scan_inc;
  logic [IW-1:0]        cur_idx;
  logic signed [CW-1:0] site_x, site_y;
  logic [R2_W-1:0]      site_r2;
  logic signed [CW:0]   dx, dy, ndx, ndy;
  logic [CW-1:0]        ax_d, ay_d;
  logic [A_W-1:0]       mul_a;
  logic [R2_W-1:0]      mul_b;
  logic [P_W-1:0]       mul_p;
  logic [WIDE_W-1:0]    rhs;
  logic                 l_less;
  logic                 site_we;
  logic                 cnt_we;
  logic [IW-1:0]        cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]     cnt_wdata, cnt_rdata, cnt_inc;

  if (CW <= COORD_W) begin : g_coord_narrow
    assign px_in = in_item_i.pos_x[CW-1:0];
    assign py_in = in_item_i.pos_y[CW-1:0];
  end else begin : g_coord_wide
    assign px_in = CW'(signed'(in_item_i.pos_x));
    assign py_in = CW'(signed'(in_item_i.pos_y));
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign lim_in     = (32'(cfg_q) > LIM) ? NW'(LIM) : NW'(cfg_q);
  assign empty_in   = (in_item_i.req_type == REQ_CLASSIFY) && (lim_in == '0);
  assign scan_inc   = scan_q + 1'b1;
  assign last_site  = (scan_inc == n_q);
  assign cur_idx    = IW'(scan_q);

  assign dx   = (CW + 1)'(px_q) - (CW + 1)'(site_x);
  assign dy   = (CW + 1)'(py_q) - (CW + 1)'(site_y);
  assign ndx  = -dx;
  assign ndy  = -dy;
  assign ax_d = dx[CW] ? ndx[CW-1:0] : dx[CW-1:0];
  assign ay_d = dy[CW] ? ndy[CW-1:0] : dy[CW-1:0];

  assign rhs    = racc_q + (WIDE_W'(mul_p) << CH);
  assign l_less = (l_q < rhs);

  assign cnt_inc = (cnt_rdata == CNT_MAX) ? cnt_rdata : cnt_rdata + 1'b1;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_ISSUE: begin
        mul_a = A_W'(rad_q);
        mul_b = R2_W'(rad_q);
      end
      ST_C_SQX: begin
        mul_a = A_W'(ax_q);
        mul_b = R2_W'(ax_q);
      end
      ST_C_SQY: begin
        mul_a = A_W'(ay_q);
        mul_b = R2_W'(ay_q);
      end
      ST_C_L0: begin
        mul_a = A_W'(d_q[CH-1:0]);
        mul_b = br2_q;
      end
      ST_C_L1: begin
        mul_a = A_W'(d_q[DW-1:CH]);
        mul_b = br2_q;
      end
      ST_C_R0: begin
        mul_a = A_W'(bd_q[CH-1:0]);
        mul_b = r2_q;
      end
      ST_C_R1: begin
        mul_a = A_W'(bd_q[DW-1:CH]);
        mul_b = r2_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  wnsc_mul #(
    .A_W (A_W)
  ) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign site_we = (state_q == ST_TAKE) && (req_q == REQ_WRITE) && in_range_q;

  wnsc_site_mem #(
    .MAX_SITES  (MAX_SITES),
    .COORD_BITS (COORD_BITS)
  ) u_site_mem (
    .clk_i   (clk_i),
    .we_i    (site_we),
    .waddr_i (IW'(idx_q)),
    .wx_i    (px_q),
    .wy_i    (py_q),
    .wr2_i   (mul_p[R2_W-1:0]),
    .raddr_i (cur_idx),
    .rx_o    (site_x),
    .ry_o    (site_y),
    .rr2_o   (site_r2)
  );

  assign cnt_we    = (state_q == ST_CLEAR) || (state_q == ST_C_UPD);
  assign cnt_waddr = (state_q == ST_CLEAR) ? clr_q : best_q;
  assign cnt_wdata = (state_q == ST_CLEAR) ? '0 : cnt_inc;
  assign cnt_raddr = (state_q == ST_C_CNT) ? best_q : IW'(idx_q);

  wnsc_cnt_mem #(
    .MAX_SITES (MAX_SITES)
  ) u_cnt_mem (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  always_comb begin
    state_d     = state_q;
    boot_d      = boot_q;
    clr_d       = clr_q;
    scan_d      = scan_q;
    have_d      = have_q;
    best_d      = best_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          scan_d = '0;
          have_d = 1'b0;
          best_d = '0;
          clr_d  = '0;
          unique case (in_item_i.req_type) inside
            REQ_WRITE, REQ_READ: state_d = ST_ISSUE;
            REQ_CLASSIFY:        state_d = empty_in ? ST_DONE : ST_C_RD;
            REQ_CLEAR:           state_d = ST_CLEAR;
            default:             state_d = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: begin
        if (clr_q == IW'(MAX_SITES - 1)) begin
          state_d = boot_q ? ST_IDLE : ST_DONE;
          boot_d  = 1'b0;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      ST_ISSUE:  state_d = ST_TAKE;
      ST_TAKE:   state_d = ST_DONE;
      ST_C_RD:   state_d = ST_C_DIFF;
      ST_C_DIFF: begin
        if (site_r2 == '0) begin
          state_d = last_site ? ST_C_CNT : ST_C_RD;
          scan_d  = last_site ? scan_q : scan_inc;
        end else begin
          state_d = ST_C_SQX;
        end
      end
      ST_C_SQX:  state_d = ST_C_SQY;
      ST_C_SQY:  state_d = ST_C_SUM;
      ST_C_SUM:  state_d = ST_C_L0;
      ST_C_L0: begin
        if (!have_q) begin
          have_d  = 1'b1;
          best_d  = cur_idx;
          state_d = last_site ? ST_C_CNT : ST_C_RD;
          scan_d  = last_site ? scan_q : scan_inc;
        end else begin
          state_d = ST_C_L1;
        end
      end
      ST_C_L1:   state_d = ST_C_R0;
      ST_C_R0:   state_d = ST_C_R1;
      ST_C_R1:   state_d = ST_C_CMP;
      ST_C_CMP: begin
        if (l_less) begin
          best_d = cur_idx;
        end
        state_d = last_site ? ST_C_CNT : ST_C_RD;
        scan_d  = last_site ? scan_q : scan_inc;
      end
      ST_C_CNT:  state_d = ST_C_UPD;
      ST_C_UPD:  state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      boot_q      <= 1'b1;
      clr_q       <= '0;
      scan_q      <= '0;
      have_q      <= 1'b0;
      best_q      <= '0;
      out_valid_q <= 1'b0;
      cfg_q       <= '0;
    end else begin
      state_q     <= state_d;
      boot_q      <= boot_d;
      clr_q       <= clr_d;
      scan_q      <= scan_d;
      have_q      <= have_d;
      best_q      <= best_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q       <= in_item_i.req_type;
      idx_q       <= in_item_i.entry_index;
      in_range_q  <= (32'(in_item_i.entry_index) < MAX_SITES);
      px_q        <= px_in;
      py_q        <= py_in;
      rad_q       <= in_item_i.site_radius;
      n_q         <= lim_in;
      res_idx_q   <= empty_in ? '0 : in_item_i.entry_index;
      res_cnt_q   <= '0;
      res_empty_q <= empty_in;
    end
    unique case (state_q)
      ST_TAKE: res_cnt_q <= in_range_q ? cnt_rdata : '0;
      ST_C_DIFF: begin
        ax_q <= ax_d;
        ay_q <= ay_d;
        r2_q <= site_r2;
      end
      ST_C_SQY: sqx_q <= mul_p[SQ_W-1:0];
      ST_C_SUM: d_q <= DW'(sqx_q) + DW'(mul_p[SQ_W-1:0]);
      ST_C_L0: begin
        if (!have_q) begin
          bd_q  <= d_q;
          br2_q <= r2_q;
        end
      end
      ST_C_L1: l_q <= WIDE_W'(mul_p);
      ST_C_R0: l_q <= l_q + (WIDE_W'(mul_p) << CH);
      ST_C_R1: racc_q <= WIDE_W'(mul_p);
      ST_C_CMP: begin
        if (l_less) begin
          bd_q  <= d_q;
          br2_q <= r2_q;
        end
      end
      ST_C_UPD: begin
        res_idx_q <= IDX_W'(best_q);
        res_cnt_q <= cnt_inc;
      end
      ST_DONE: begin
        if (out_free) begin
          out_item_q.nearest_index <= res_idx_q;
          out_item_q.hit_count     <= res_cnt_q;
          out_item_q.table_empty   <= res_empty_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `ASSERT_AR(a_empty_result, clk_i, rst_ni, out_valid_o && out_item_o.table_empty |-> out_item_o.nearest_index == '0 && out_item_o.hit_count == '0)
  `ASSERT_AR(a_hit_counted, clk_i, rst_ni, $rose(out_valid_o) && req_q == REQ_CLASSIFY && !out_item_o.table_empty |-> out_item_o.hit_count != '0)
  `ASSERT_AR(a_scan_bound, clk_i, rst_ni, (state_q == ST_C_RD || state_q == ST_C_DIFF || state_q == ST_C_CMP) |-> scan_q < n_q)
  `ASSERT_AR(a_out_held, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))

endmodule

### rtl/core/wnsc_mul.sv
module wnsc_mul
  import wnsc_pkg::*;
#(
  parameter int A_W = RAD_W
) (
  input  logic                  clk_i,
  input  logic [A_W-1:0]        a_i,
  input  logic [R2_W-1:0]       b_i,
  output logic [A_W+R2_W-1:0]   p_o
);

  logic [A_W+R2_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

### rtl/core/wnsc_site_mem.sv
module wnsc_site_mem
  import wnsc_pkg::*;
#(
  parameter int MAX_SITES  = MAX_SITES_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [((MAX_SITES > 1) ? $clog2(MAX_SITES) : 1)-1:0] waddr_i,
  input  logic signed [COORD_BITS-1:0]  wx_i,
  input  logic signed [COORD_BITS-1:0]  wy_i,
  input  logic [R2_W-1:0]               wr2_i,
  input  logic [((MAX_SITES > 1) ? $clog2(MAX_SITES) : 1)-1:0] raddr_i,
  output logic signed [COORD_BITS-1:0]  rx_o,
  output logic signed [COORD_BITS-1:0]  ry_o,
  output logic [R2_W-1:0]               rr2_o
);

  localparam int EW = 2 * COORD_BITS + R2_W;

  logic [EW-1:0] mem [MAX_SITES];
  logic [EW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= {wx_i, wy_i, wr2_i};
    end
    rdata_q <= mem[raddr_i];
  end

  assign rx_o  = rdata_q[EW-1 -: COORD_BITS];
  assign ry_o  = rdata_q[R2_W +: COORD_BITS];
  assign rr2_o = rdata_q[R2_W-1:0];

endmodule

### rtl/core/wnsc_cnt_mem.sv
module wnsc_cnt_mem
  import wnsc_pkg::*;
#(
  parameter int MAX_SITES = MAX_SITES_DEF
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [((MAX_SITES > 1) ? $clog2(MAX_SITES) : 1)-1:0] waddr_i,
  input  logic [CNT_W-1:0]        wdata_i,
  input  logic [((MAX_SITES > 1) ? $clog2(MAX_SITES) : 1)-1:0] raddr_i,
  output logic [CNT_W-1:0]        rdata_o
);

  logic [CNT_W-1:0] mem [MAX_SITES];
  logic [CNT_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### tb/sv/tb_weighted_nearest_site_classifier.sv
`timescale 1ns / 100ps

module tb_weighted_nearest_site_classifier;
  import wnsc_pkg::*;

  localparam int SITES = MAX_SITES_DEF;
  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 100;
  localparam int BURST_ITEMS = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  wnsc_in_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  wnsc_out_t out_item;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  logic signed [COORD_W-1:0] site_x [SITES];
  logic signed [COORD_W-1:0] site_y [SITES];
  logic [RAD_W-1:0] site_r [SITES];
  logic [CNT_W-1:0] site_hits [SITES];
  int unsigned sites_in_use = 0;
  wnsc_out_t awaited_results [$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  bit in_gaps_on = 1'b1;
  bit out_gaps_on = 1'b1;

  weighted_nearest_site_classifier DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t ns: %s", $time, msg);
  endtask

  // The winner has the least distance over radius, compared by cross products.
  function automatic wnsc_out_t classify_point(input logic signed [COORD_W-1:0] px,
                                               input logic signed [COORD_W-1:0] py);
    wnsc_out_t res;
    int unsigned n;
    int best;
    bit found;
    longint dx, dy;
    bit [63:0] sq_dist, rad2, best_dist, best_rad2;
    bit [127:0] lhs, rhs;
    res = '0;
    n = (sites_in_use > SITES) ? SITES : sites_in_use;
    if (n == 0) begin
      res.table_empty = 1'b1;
      return res;
    end
    best = 0;
    found = 1'b0;
    best_dist = '0;
    best_rad2 = '0;
    for (int i = 0; i < n; i++) begin
      if (site_r[i] != '0) begin
        dx = longint'(px) - longint'(site_x[i]);
        dy = longint'(py) - longint'(site_y[i]);
        sq_dist = 64'(dx * dx + dy * dy);
        rad2 = 64'(site_r[i]) * 64'(site_r[i]);
        lhs = 128'(sq_dist) * 128'(best_rad2);
        rhs = 128'(best_dist) * 128'(rad2);
        if (!found || lhs < rhs) begin
          best = i;
          best_dist = sq_dist;
          best_rad2 = rad2;
          found = 1'b1;
        end
      end
    end
    if (site_hits[best] != CNT_MAX) begin
      site_hits[best] = site_hits[best] + 1'b1;
    end
    res.nearest_index = IDX_W'(best);
    res.hit_count = site_hits[best];
    return res;
  endfunction

  task automatic apply_request(input wnsc_in_t it);
    wnsc_out_t res;
    res = '0;
    res.nearest_index = it.entry_index;
    case (it.req_type)
      REQ_WRITE: begin
        site_x[it.entry_index] = it.pos_x;
        site_y[it.entry_index] = it.pos_y;
        site_r[it.entry_index] = it.site_radius;
        res.hit_count = site_hits[it.entry_index];
      end
      REQ_CLASSIFY: begin
        res = classify_point(it.pos_x, it.pos_y);
      end
      REQ_READ: begin
        res.hit_count = site_hits[it.entry_index];
      end
      default: begin
        foreach (site_hits[i]) site_hits[i] = '0;
      end
    endcase
    awaited_results.insert(awaited_results.size(), res);
  endtask

  function automatic wnsc_in_t make_item(input wnsc_req_e req, input int idx,
                                         input int x, input int y, input int r);
    wnsc_in_t it;
    it.req_type = req;
    it.entry_index = IDX_W'(idx);
    it.pos_x = COORD_W'(x);
    it.pos_y = COORD_W'(y);
    it.site_radius = RAD_W'(r);
    return it;
  endfunction

  function automatic logic signed [COORD_W-1:0] random_coord();
    int pick;
    pick = $urandom_range(0, 5);
    if (pick == 0) begin
      return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    end else if (pick <= 2) begin
      return COORD_W'(int'($urandom_range(0, 600)) - 300);
    end
    return COORD_W'($urandom);
  endfunction

  function automatic logic [RAD_W-1:0] random_radius();
    int pick;
    pick = $urandom_range(0, 39);
    if (pick == 0) begin
      return '0;
    end else if (pick == 1) begin
      return '1;
    end else if (pick <= 14) begin
      return RAD_W'($urandom_range(1, 64));
    end else if (pick <= 24) begin
      return RAD_W'($urandom_range(1, 2000));
    end
    return RAD_W'($urandom);
  endfunction

  function automatic wnsc_in_t random_request();
    wnsc_in_t it;
    int pick;
    pick = $urandom_range(0, 99);
    it = make_item(REQ_CLASSIFY, $urandom_range(0, SITES - 1), random_coord(),
                   random_coord(), random_radius());
    if (pick < 25) begin
      it.req_type = REQ_WRITE;
    end else if (pick < 38) begin
      it.req_type = REQ_READ;
    end else if (pick < 41) begin
      it.req_type = REQ_CLEAR;
    end
    return it;
  endfunction

  task automatic pause_sender(input int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic send_item(input wnsc_in_t it);
    if (in_gaps_on && $urandom_range(0, 7) == 0) begin
      pause_sender($urandom_range(1, 17));
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    apply_request(it);
  endtask

  task automatic wait_idle();
    pause_sender(1);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_sites_in_use(input int value);
    wait_idle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= CFG_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    sites_in_use = value;
  endtask

  task automatic test_empty_table();
    set_sites_in_use(0);
    send_item(make_item(REQ_CLASSIFY, 17, 32767, -32768, 1));
    send_item(make_item(REQ_READ, 63, 0, 0, 1));
    send_item(make_item(REQ_CLEAR, 5, -1, -1, 65535));
    send_item(make_item(REQ_WRITE, 0, -32768, -32768, 65535));
  endtask

  task automatic test_ties();
    send_item(make_item(REQ_WRITE, 0, 1001, 1000, 1));
    send_item(make_item(REQ_WRITE, 1, 1002, 1000, 2));
    send_item(make_item(REQ_WRITE, 2, 1001, 1000, 1));
    set_sites_in_use(3);
    send_item(make_item(REQ_CLASSIFY, 0, 1000, 1000, 1));
    send_item(make_item(REQ_CLASSIFY, 0, 1003, 1000, 1));
    send_item(make_item(REQ_READ, 0, 0, 0, 1));
    send_item(make_item(REQ_READ, 1, 0, 0, 1));
  endtask

  task automatic test_zero_radius();
    send_item(make_item(REQ_WRITE, 0, 0, 0, 0));
    set_sites_in_use(1);
    send_item(make_item(REQ_CLASSIFY, 9, 5, 5, 1));
    set_sites_in_use(3);
    send_item(make_item(REQ_CLASSIFY, 9, 1000, 1000, 1));
  endtask

  // A lone site of zero radius wins every point, so its counter counts each one.
  task automatic test_single_site_burst();
    in_gaps_on = 1'b0;
    out_gaps_on = 1'b0;
    send_item(make_item(REQ_WRITE, 0, 123, -456, 0));
    set_sites_in_use(1);
    repeat (BURST_ITEMS) begin
      send_item(make_item(REQ_CLASSIFY, $urandom_range(0, SITES - 1), random_coord(),
                          random_coord(), random_radius()));
    end
    send_item(make_item(REQ_READ, 0, 0, 0, 1));
    send_item(make_item(REQ_CLEAR, 0, 0, 0, 1));
    in_gaps_on = 1'b1;
    out_gaps_on = 1'b1;
  endtask

  task automatic test_coordinate_extremes();
    send_item(make_item(REQ_WRITE, 0, -32768, -32768, 65535));
    send_item(make_item(REQ_WRITE, 1, 32767, 32767, 1));
    send_item(make_item(REQ_WRITE, 2, 32767, -32768, 65535));
    send_item(make_item(REQ_WRITE, 3, -32768, 32767, 1));
    set_sites_in_use(4);
    send_item(make_item(REQ_CLASSIFY, 0, 32767, 32767, 1));
    send_item(make_item(REQ_CLASSIFY, 0, -32768, -32768, 1));
    send_item(make_item(REQ_CLASSIFY, 0, 32767, -32768, 1));
    send_item(make_item(REQ_CLASSIFY, 0, -32768, 32767, 1));
    send_item(make_item(REQ_CLASSIFY, 0, 0, 0, 1));
  endtask

  task automatic test_full_table();
    for (int i = 0; i < SITES; i++) begin
      send_item(make_item(REQ_WRITE, i, random_coord(), random_coord(), random_radius()));
    end
    set_sites_in_use(SITES);
    repeat (3) send_item(make_item(REQ_CLASSIFY, 0, random_coord(), random_coord(), 1));
    set_sites_in_use(127);
    repeat (3) send_item(make_item(REQ_CLASSIFY, 0, random_coord(), random_coord(), 1));
  endtask

  task automatic test_random_traffic();
    int n;
    int items;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: n = 1;
        1: n = 127;
        2: n = $urandom_range(2, 16);
        3: n = SITES;
        4: n = $urandom_range(1, 16);
        default: n = $urandom_range(17, 40);
      endcase
      set_sites_in_use(n);
      in_gaps_on = (phase != 5) && (phase != 2);
      out_gaps_on = (phase != 5) && (phase != 4);
      items = (n >= 48) ? 60 : 200;
      repeat (items) send_item(random_request());
    end
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (out_gaps_on && $urandom_range(0, 11) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_result
    wnsc_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("result with no item awaiting it, index %0d",
                                  out_item.nearest_index));
      end else begin
        want = awaited_results.pop_front();
        if (out_item.nearest_index !== want.nearest_index) begin
          report_mismatch($sformatf("nearest_index got %0d expected %0d",
                                    out_item.nearest_index, want.nearest_index));
        end
        if (out_item.hit_count !== want.hit_count) begin
          report_mismatch($sformatf("hit_count got %0d expected %0d",
                                    out_item.hit_count, want.hit_count));
        end
        if (out_item.table_empty !== want.table_empty) begin
          report_mismatch($sformatf("table_empty got %0b expected %0b",
                                    out_item.table_empty, want.table_empty));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL weighted_nearest_site_classifier");
        $finish;
      end
    end
  end

  initial begin
    foreach (site_hits[i]) site_hits[i] = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_ties();
    test_zero_radius();
    test_single_site_burst();
    test_coordinate_extremes();
    test_full_table();
    test_random_traffic();
    wait_idle();
    if (mismatches == 0) begin
      $display("PASS weighted_nearest_site_classifier");
    end else begin
      $display("FAIL weighted_nearest_site_classifier");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/wnsc_pkg.sv
rtl/core/wnsc_mul.sv
rtl/core/wnsc_site_mem.sv
rtl/core/wnsc_cnt_mem.sv
rtl/core/weighted_nearest_site_classifier.sv
tb/sv/tb_weighted_nearest_site_classifier.sv
